/* src/rmel_pkg.sv */
// shared types and constants for the running median latency smoother
package rmel_pkg;

	// fixed field widths
	localparam int SAMPLE_IN_W = 48;
	localparam int MEDIAN_W    = 40;
	localparam int EST_W       = 56;
	localparam int ALPHA_W     = 17;

	// q16 unity weight and reset weight (0.01)
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd655;

	// multiplier operand selection for the ewma steps
	typedef enum logic [1:0] {
		MUL_LO,
		MUL_HI,
		MUL_MED
	} mul_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     scan;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_first;
		logic     acc_add;
		logic     update;
		logic     publish;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sample_pos;
		logic scan_last;
		logic est_zero;
		logic out_free;
	} dp_status_t;

endpackage

/* src/rmel_ctrl.sv */
// controller state machine for the running median latency smoother
module rmel_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rmel_pkg::dp_status_t status,
	output rmel_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_MED,
		ST_ACC,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_next;

	// input side is open only while idle
	assign in_stall = (state_q != ST_IDLE);

	// next state and command decode
	always_comb begin
		state_next  = state_q;
		cmd         = '0;
		cmd.mul_sel = rmel_pkg::MUL_LO;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = status.sample_pos ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_next = status.est_zero ? ST_UPDATE : ST_MUL_LO;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rmel_pkg::MUL_LO;
				state_next  = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = rmel_pkg::MUL_HI;
				cmd.acc_first = 1'b1;
				state_next    = ST_MUL_MED;
			end
			ST_MUL_MED: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rmel_pkg::MUL_MED;
				cmd.acc_add = 1'b1;
				state_next  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_next  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_next  = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

/* src/rmel_datapath.sv */
// window, median scan, ewma multiplier and result register
module rmel_datapath #(
	parameter int WINDOW_SIZE = 5,
	parameter int SAMPLE_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [rmel_pkg::SAMPLE_IN_W-1:0] sample_ns,
	input  logic                                cfg_wr,
	input  logic [rmel_pkg::ALPHA_W-1:0]        alpha_q16,
	input  rmel_pkg::dp_cmd_t                   cmd,
	output rmel_pkg::dp_status_t                status,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic                                accepted,
	output logic [rmel_pkg::MEDIAN_W-1:0]       median_ns,
	output logic [rmel_pkg::EST_W-1:0]          smoothed_q16,
	output logic                                estimate_valid
);

	localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
	localparam int MID    = WINDOW_SIZE / 2;
	localparam int MB     = (SAMPLE_BITS > rmel_pkg::MEDIAN_W) ? SAMPLE_BITS
		: rmel_pkg::MEDIAN_W;
	localparam int PW     = rmel_pkg::ALPHA_W + MB;
	localparam int EW     = rmel_pkg::EST_W;
	localparam logic [rmel_pkg::SAMPLE_IN_W-1:0] MAXV =
		(rmel_pkg::SAMPLE_IN_W'(1) << SAMPLE_BITS) - rmel_pkg::SAMPLE_IN_W'(1);

	logic [SAMPLE_BITS-1:0]          win_q [WINDOW_SIZE];
	logic [SLOT_W-1:0]               slot_q;
	logic [SLOT_W-1:0]               scan_idx_q;
	logic                            wrap_q;
	logic                            pos_q;
	logic [SAMPLE_BITS-1:0]          median_q;
	logic [EW-1:0]                   est_q;
	logic [EW-1:0]                   acc_q;
	logic [EW-1:0]                   prod_s1;
	logic [rmel_pkg::ALPHA_W-1:0]    alpha_q;
	logic                            out_valid_q;
	logic                            out_acc_q;
	logic [rmel_pkg::MEDIAN_W-1:0]   out_median_q;
	logic [EW-1:0]                   out_est_q;
	logic                            out_estv_q;

	logic [rmel_pkg::SAMPLE_IN_W-1:0] raw;
	logic                             pos;
	logic [SAMPLE_BITS-1:0]           sat;
	logic                             slot_last;
	logic [SAMPLE_BITS-1:0]           cand;
	logic [WINDOW_SIZE-1:0]           lt_vec;
	logic [WINDOW_SIZE-1:0]           le_vec;
	logic [CNT_W-1:0]                 lt_cnt;
	logic [CNT_W-1:0]                 le_cnt;
	logic                             found;
	logic [rmel_pkg::ALPHA_W-1:0]     a_eff;
	logic [rmel_pkg::ALPHA_W-1:0]     w_eff;
	logic [rmel_pkg::ALPHA_W-1:0]     mul_a;
	logic [MB-1:0]                    mul_b;
	logic [PW-1:0]                    prod_full;
	logic [EW-1:0]                    seed;
	logic                             out_free;

	// sample qualification and saturation
	assign raw       = sample_ns;
	assign pos       = !raw[rmel_pkg::SAMPLE_IN_W-1] && (raw != '0);
	assign sat       = SAMPLE_BITS'((raw > MAXV) ? MAXV : raw);
	assign slot_last = (slot_q == SLOT_W'(WINDOW_SIZE - 1));

	// rank of the current candidate against the whole window
	assign cand = win_q[scan_idx_q];
	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			lt_vec[i] = (win_q[i] < cand);
			le_vec[i] = (win_q[i] <= cand);
		end
	end
	assign lt_cnt = CNT_W'($countones(lt_vec));
	assign le_cnt = CNT_W'($countones(le_vec));
	assign found  = (lt_cnt <= CNT_W'(MID)) && (CNT_W'(MID) < le_cnt);

	// ewma weights, alpha clamped to one
	assign a_eff = (alpha_q > rmel_pkg::ALPHA_ONE) ? rmel_pkg::ALPHA_ONE : alpha_q;
	assign w_eff = rmel_pkg::ALPHA_ONE - a_eff;

	// shared multiplier operand selection
	always_comb begin
		case (cmd.mul_sel)
			rmel_pkg::MUL_LO: begin
				mul_a = w_eff;
				mul_b = MB'(est_q[15:0]);
			end
			rmel_pkg::MUL_HI: begin
				mul_a = w_eff;
				mul_b = MB'(est_q[EW-1:16]);
			end
			rmel_pkg::MUL_MED: begin
				mul_a = a_eff;
				mul_b = MB'(median_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod_full = PW'(mul_a) * PW'(mul_b);

	// first estimate is the median in q16
	assign seed = EW'(median_q) << 16;

	assign out_free = !out_valid_q || !out_stall;

	assign status.sample_pos = pos;
	assign status.scan_last  = (scan_idx_q == SLOT_W'(WINDOW_SIZE - 1));
	assign status.est_zero   = (est_q == '0);
	assign status.out_free   = out_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= rmel_pkg::ALPHA_RESET;
		end else if (cfg_wr) begin
			alpha_q <= alpha_q16;
		end
	end

	// window, slot, median and estimate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				win_q[i] <= '0;
			end
			slot_q     <= '0;
			scan_idx_q <= '0;
			wrap_q     <= 1'b0;
			pos_q      <= 1'b0;
			median_q   <= '0;
			est_q      <= '0;
		end else begin
			if (cmd.load) begin
				pos_q      <= pos;
				scan_idx_q <= '0;
				if (pos) begin
					win_q[slot_q] <= sat;
					wrap_q        <= slot_last;
					slot_q        <= slot_last ? '0 : slot_q + SLOT_W'(1);
				end
			end
			if (cmd.scan) begin
				if (found) begin
					median_q <= cand;
				end
				if (!status.scan_last) begin
					scan_idx_q <= scan_idx_q + SLOT_W'(1);
				end
			end
			if (cmd.update) begin
				if (est_q == '0) begin
					if (wrap_q) begin
						est_q <= seed;
					end
				end else begin
					est_q <= acc_q;
				end
			end
		end
	end

	// multiplier product register and accumulator
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= prod_full[EW-1:0];
		end
		if (cmd.acc_first) begin
			acc_q <= EW'(prod_s1[EW-1:16]);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_acc_q    <= pos_q;
			out_median_q <= rmel_pkg::MEDIAN_W'(median_q);
			out_est_q    <= est_q;
			out_estv_q   <= (est_q != '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = out_acc_q;
	assign median_ns      = out_median_q;
	assign smoothed_q16   = out_est_q;
	assign estimate_valid = out_estv_q;

endmodule

/* src/running_median_ewma_latency.sv */
// top level of the running median latency smoother
//
// Input channel: sample_ns with in_valid / in_stall; a beat moves when in_valid
// is high and in_stall is low. Nonpositive samples pass through the block and
// only report the current median and estimate.
// Output channel: accepted, median_ns, smoothed_q16, estimate_valid with
// out_valid / out_stall. The result sits in an output register, so a stalled
// result does not keep the block from taking and working on the next sample;
// that sample then waits only for the register to free up before it is shown.
// Config channel: alpha_q16 with cfg_valid / cfg_ready; cfg_ready is always high.
// Steps per sample, from the input beat to the result register:
//   nonpositive sample: straight to the result register
//   positive, estimate not yet seeded: median scan, then update
//   positive, estimate running: median scan, three multiplies, accumulate, update
// The median scan tests one window entry per cycle against all others, and the
// ewma takes three passes through one shared multiplier plus accumulate.
// The next sample is taken the cycle after a result is registered.
// Reset clears the window, the slot pointer and the estimate, and sets alpha
// to 655 (0.01).
module running_median_ewma_latency #(
	parameter int WINDOW_SIZE = 5,
	parameter int SAMPLE_BITS = 40
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [rmel_pkg::SAMPLE_IN_W-1:0] sample_ns,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    accepted,
	output logic [rmel_pkg::MEDIAN_W-1:0]           median_ns,
	output logic [rmel_pkg::EST_W-1:0]              smoothed_q16,
	output logic                                    estimate_valid,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rmel_pkg::ALPHA_W-1:0]            alpha_q16
);

	rmel_pkg::dp_cmd_t    cmd;
	rmel_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	rmel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// window and arithmetic
	rmel_datapath #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_ns      (sample_ns),
		.cfg_wr         (cfg_valid && cfg_ready),
		.alpha_q16      (alpha_q16),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.accepted       (accepted),
		.median_ns      (median_ns),
		.smoothed_q16   (smoothed_q16),
		.estimate_valid (estimate_valid)
	);

endmodule

/* verif/running_median_ewma_latency_tb.sv */
// self-checking testbench for the running median latency smoother
`timescale 1ns / 1ps

module running_median_ewma_latency_tb;

	localparam int WINDOW_SIZE = 5;
	localparam int SAMPLE_BITS = 40;
	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES  = 8;
	localparam int TAIL_CYCLES = 40;
	localparam logic [rmel_pkg::SAMPLE_IN_W-1:0] SAMPLE_SAT =
		(48'd1 << SAMPLE_BITS) - 48'd1;
	localparam logic [rmel_pkg::SAMPLE_IN_W-1:0] NEG_MIN = 48'h8000_0000_0000;
	localparam logic [rmel_pkg::SAMPLE_IN_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;

	// one result beat as the block reports it
	typedef struct {
		logic                          accepted;
		logic [rmel_pkg::MEDIAN_W-1:0] median;
		logic [rmel_pkg::EST_W-1:0]    smoothed;
		logic                          seeded;
	} estimate_t;

	// tracks window, slot and estimate, and holds the estimates still owed
	class smoother_scoreboard_t;
		logic [rmel_pkg::MEDIAN_W-1:0] window [WINDOW_SIZE];
		int                            slot;
		logic [rmel_pkg::EST_W-1:0]    estimate;
		logic [rmel_pkg::ALPHA_W-1:0]  alpha;
		estimate_t                     owed_estimates[$];
		int                            errors;

		function new();
			foreach (window[i]) window[i] = '0;
			slot     = 0;
			estimate = '0;
			alpha    = rmel_pkg::ALPHA_RESET;
			errors   = 0;
		endfunction

		function void set_alpha(logic [rmel_pkg::ALPHA_W-1:0] v);
			alpha = v;
		endfunction

		function int pending();
			return owed_estimates.size();
		endfunction

		// upper median of the window, sorted ascending
		function logic [rmel_pkg::MEDIAN_W-1:0] window_median();
			logic [rmel_pkg::MEDIAN_W-1:0] sorted [WINDOW_SIZE];
			logic [rmel_pkg::MEDIAN_W-1:0] tmp;
			sorted = window;
			for (int i = 0; i < WINDOW_SIZE; i++)
				for (int j = 0; j < WINDOW_SIZE - 1 - i; j++)
					if (sorted[j] > sorted[j+1]) begin
						tmp         = sorted[j];
						sorted[j]   = sorted[j+1];
						sorted[j+1] = tmp;
					end
			return sorted[WINDOW_SIZE/2];
		endfunction

		// truncating q16 blend of the estimate toward the median
		function logic [rmel_pkg::EST_W-1:0] blend(logic [rmel_pkg::EST_W-1:0] s,
				logic [rmel_pkg::MEDIAN_W-1:0] med);
			logic [127:0] a;
			logic [127:0] w;
			logic [127:0] acc;
			a   = (alpha > rmel_pkg::ALPHA_ONE) ? 128'(rmel_pkg::ALPHA_ONE) : 128'(alpha);
			w   = 128'(rmel_pkg::ALPHA_ONE) - a;
			acc = (w * 128'(s) + a * (128'(med) << 16)) >> 16;
			return acc[rmel_pkg::EST_W-1:0];
		endfunction

		// accepted input beat: advance the state and queue the owed estimate
		function void note_sample(logic [rmel_pkg::SAMPLE_IN_W-1:0] raw);
			estimate_t                     r;
			logic [rmel_pkg::MEDIAN_W-1:0] med;
			logic                          pos;
			pos = !raw[rmel_pkg::SAMPLE_IN_W-1] && (raw != '0);
			if (slot >= WINDOW_SIZE) slot = 0;
			if (pos) begin
				window[slot] = (raw > SAMPLE_SAT) ? SAMPLE_SAT[rmel_pkg::MEDIAN_W-1:0]
					: raw[rmel_pkg::MEDIAN_W-1:0];
				slot++;
				if (slot >= WINDOW_SIZE) slot = 0;
				med = window_median();
				if (estimate == '0 && slot == 0)
					estimate = {med, 16'h0000};
				else if (estimate != '0)
					estimate = blend(estimate, med);
			end else begin
				med = window_median();
			end
			r.accepted = pos;
			r.median   = med;
			r.smoothed = estimate;
			r.seeded   = (estimate != '0);
			owed_estimates.push_back(r);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s expected %0h actual %0h", field, want, got);
				errors++;
			end
		endfunction

		// result beat: compare with the oldest owed estimate
		function void check_estimate(logic acc, logic [rmel_pkg::MEDIAN_W-1:0] med,
				logic [rmel_pkg::EST_W-1:0] sm, logic ev);
			estimate_t r;
			if (owed_estimates.size() == 0) begin
				$error("result beat with no estimate owed");
				errors++;
			end else begin
				r = owed_estimates.pop_front();
				compare_field("accepted", 64'(r.accepted), 64'(acc));
				compare_field("median_ns", 64'(r.median), 64'(med));
				compare_field("smoothed_q16", 64'(r.smoothed), 64'(sm));
				compare_field("estimate_valid", 64'(r.seeded), 64'(ev));
			end
		endfunction
	endclass

	logic                                    clk;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_stall;
	logic signed [rmel_pkg::SAMPLE_IN_W-1:0] sample_ns;
	logic                                    out_valid;
	logic                                    out_stall;
	logic                                    accepted;
	logic [rmel_pkg::MEDIAN_W-1:0]           median_ns;
	logic [rmel_pkg::EST_W-1:0]              smoothed_q16;
	logic                                    estimate_valid;
	logic                                    cfg_valid;
	logic                                    cfg_ready;
	logic [rmel_pkg::ALPHA_W-1:0]            alpha_q16;

	smoother_scoreboard_t sb;
	logic                 calm;
	int                   idle_pct;
	int                   base_ns;

	running_median_ewma_latency #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_ns     (sample_ns),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.median_ns     (median_ns),
		.smoothed_q16  (smoothed_q16),
		.estimate_valid(estimate_valid),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.alpha_q16     (alpha_q16)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_estimate(accepted, median_ns, smoothed_q16, estimate_valid);
	end

	// receiver stalls in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one input beat, then maybe an idle burst
	task automatic send_sample(input logic [rmel_pkg::SAMPLE_IN_W-1:0] s);
		int          gap;
		logic [63:0] junk;
		in_valid  <= 1'b1;
		sample_ns <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_sample(s);
		gap = 0;
		if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 7);
		if (gap > 0) begin
			junk       = {$urandom, $urandom};
			in_valid  <= 1'b0;
			sample_ns <= junk[rmel_pkg::SAMPLE_IN_W-1:0];
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every owed estimate is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [rmel_pkg::ALPHA_W-1:0] v);
		cfg_valid <= 1'b1;
		alpha_q16 <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_alpha(v);
		cfg_valid <= 1'b0;
	endtask

	// random latency: mostly plausible values, some noise and extremes
	function automatic logic [rmel_pkg::SAMPLE_IN_W-1:0] next_latency();
		logic [63:0] r;
		int          pick;
		r    = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return '0;
		else if (pick < 14)
			return {1'b1, r[rmel_pkg::SAMPLE_IN_W-2:0]};
		else if (pick < 22)
			return r[rmel_pkg::SAMPLE_IN_W-1:0];
		else if (pick < 30)
			return SAMPLE_SAT - 48'd8 + 48'($urandom_range(0, 16));
		else if (pick < 36)
			return {8'h00, r[rmel_pkg::MEDIAN_W-1:0]};
		else
			return 48'(base_ns) + 48'($urandom_range(0, base_ns));
	endfunction

	// stimulus
	initial begin
		logic [rmel_pkg::SAMPLE_IN_W-1:0] warmup [14];
		logic [rmel_pkg::ALPHA_W-1:0]     phase_alpha;
		sb        = new();
		calm      = 1'b0;
		idle_pct  = 0;
		base_ns   = 1000;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample_ns <= '0;
		cfg_valid <= 1'b0;
		alpha_q16 <= rmel_pkg::ALPHA_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weight: ignored samples, saturation, first wrap seeds the estimate
		warmup = '{48'd0, 48'hFFFF_FFFF_FFFF, NEG_MIN, 48'd1, POS_MAX, SAMPLE_SAT,
			SAMPLE_SAT + 48'd1, 48'd100, 48'hFFFF_FFFF_FFFB, 48'd200, 48'd50, 48'd0,
			48'd300, 48'd1000};
		foreach (warmup[i]) send_sample(warmup[i]);
		drain();

		// full weight: estimate tracks the median
		write_alpha(rmel_pkg::ALPHA_ONE);
		send_sample(48'd7);
		send_sample(NEG_MIN);
		send_sample(48'd123456);
		send_sample(48'd9);
		drain();

		// zero weight: estimate frozen
		write_alpha('0);
		send_sample(48'd5);
		send_sample(POS_MAX);
		send_sample(48'd0);
		drain();

		// weight above one is clamped
		write_alpha({rmel_pkg::ALPHA_W{1'b1}});
		send_sample(48'd42);
		send_sample(48'd77);
		send_sample(SAMPLE_SAT);
		send_sample(48'hFFFF_FFFF_FFFF);
		drain();

		// random phases, each with its own weight and idling level
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: phase_alpha = rmel_pkg::ALPHA_ONE;
				1: phase_alpha = 17'd1;
				2: phase_alpha = 17'd65535;
				3: phase_alpha = 17'($urandom_range(0, 65536));
				4: phase_alpha = '0;
				5: phase_alpha = 17'($urandom);
				6: phase_alpha = {rmel_pkg::ALPHA_W{1'b1}};
				default: phase_alpha = rmel_pkg::ALPHA_RESET;
			endcase
			write_alpha(phase_alpha);
			calm     = (p == NUM_PHASES - 1);
			idle_pct = (p % 3 == 1) ? 0 : ((p % 3 == 0) ? 20 : 45);
			base_ns  = $urandom_range(1, 200000);
			for (int k = 0; k < PHASE_ITEMS; k++) send_sample(next_latency());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
